>>> rtl/core/pli_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise-linear interpolation package
// Shared widths, codes and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int DATA_W    = 32;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = 5;

  typedef enum logic [1:0] {
    STATUS_INTERP = 2'd0,
    STATUS_LOW    = 2'd1,
    STATUS_HIGH   = 2'd2,
    STATUS_NOSEG  = 2'd3
  } status_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    RD_LAST  = 2'd0,
    RD_FIRST = 2'd1,
    RD_NEXT  = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    query_load;
    logic    load_write;
    rd_sel_t rd_sel;
    logic    chk_last;
    logic    chk_first;
    logic    scan_step;
    logic    mul;
    logic    div_step;
    logic    sum;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic ge_last;
    logic le_first;
    logic seg_hit;
    logic scan_end;
    logic out_busy;
  } sts_t;

endpackage

>>> rtl/core/pli_in_if.sv
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel that carries load and query words.
// ----------------------------------------------------------------------------
interface pli_in_if import pli_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [IDX_W-1:0]         entry_index;
  logic signed [DATA_W-1:0] x_value;
  logic signed [DATA_W-1:0] y_value;

  modport source (output valid, output kind, output entry_index, output x_value,
                  output y_value, input ready);
  modport sink (input valid, input kind, input entry_index, input x_value,
                input y_value, output ready);

endinterface

>>> rtl/core/pli_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries interpolated result words.
// ----------------------------------------------------------------------------
interface pli_out_if import pli_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_y;
  logic [1:0]               status;

  modport source (output valid, output result_y, output status, input ready);
  modport sink (input valid, input result_y, input status, output ready);

endinterface

>>> rtl/core/pli_ctrl.sv
// ----------------------------------------------------------------------------
// Interpolation controller
// Sequences one word at a time: clamp checks, segment scan, multiply, divide
// and result hand-off.
// ----------------------------------------------------------------------------
module pli_ctrl import pli_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LAST  = 8'b0000_0010,
    S_FIRST = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    cmd.rd_sel  = RD_NEXT;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.rd_sel = RD_LAST;
        if (in_valid) begin
          if (in_kind == KIND_QUERY) begin
            cmd.query_load = 1'b1;
            state_nxt      = S_LAST;
          end else begin
            cmd.load_write = 1'b1;
          end
        end
      end
      S_LAST: begin
        cmd.chk_last = 1'b1;
        cmd.rd_sel   = RD_FIRST;
        state_nxt    = sts.ge_last ? S_OUT : S_FIRST;
      end
      S_FIRST: begin
        cmd.chk_first = 1'b1;
        state_nxt     = sts.le_first ? S_OUT : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.seg_hit) begin
          state_nxt = S_MUL;
        end else if (sts.scan_end) begin
          state_nxt = S_OUT;
        end
      end
      S_MUL: begin
        cmd.mul     = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

endmodule

>>> rtl/core/pli_dpath.sv
// ----------------------------------------------------------------------------
// Interpolation datapath
// Breakpoint memory, segment compare, 32x32 multiplier, restoring divider and
// the output register.
// ----------------------------------------------------------------------------
module pli_dpath import pli_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic                     cfg_wr_en,
  input  logic [CNT_W-1:0]         cfg_wr_data,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic signed [DATA_W-1:0] in_x_value,
  input  logic signed [DATA_W-1:0] in_y_value,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_result_y,
  output logic [1:0]               out_status
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [DATA_W-1:0] ONE_VAL = DATA_W'(64'd1 << FRAC_BITS);

  logic signed [DATA_W-1:0] mem_x [TABLE_DEPTH];
  logic signed [DATA_W-1:0] mem_y [TABLE_DEPTH];

  logic [CNT_W-1:0]         entry_count_r;
  logic [AW-1:0]            n_last;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            idx_r;
  logic signed [DATA_W-1:0] rdx_q, rdy_q;
  logic signed [DATA_W-1:0] qx_r;
  logic signed [DATA_W-1:0] prev_x_r, prev_y_r;
  logic signed [DATA_W-1:0] y0_r;
  logic                     neg_r;
  logic [DATA_W-1:0]        mag_r, off_r, den_r;
  logic [DATA_W-1:0]        rem_r, quo_r;
  logic signed [DATA_W-1:0] res_r;
  status_t                  res_status_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_y_r;
  status_t                  out_status_r;

  logic signed [DATA_W:0]   dy;
  logic [DATA_W:0]          div_try;
  logic                     div_ge;

  always_comb begin
    if (32'(entry_count_r) > TABLE_DEPTH) begin
      n_last = AW'(TABLE_DEPTH - 1);
    end else if (entry_count_r == '0) begin
      n_last = '0;
    end else begin
      n_last = AW'(entry_count_r - 1'b1);
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_LAST:  rd_addr = n_last;
      RD_FIRST: rd_addr = '0;
      default:  rd_addr = idx_r + 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_write && (32'(in_entry_index) < TABLE_DEPTH)) begin
      mem_x[AW'(in_entry_index)] <= in_x_value;
      mem_y[AW'(in_entry_index)] <= in_y_value;
    end
    rdx_q <= mem_x[rd_addr];
    rdy_q <= mem_y[rd_addr];
  end

  assign sts.ge_last  = qx_r >= rdx_q;
  assign sts.le_first = qx_r <= rdx_q;
  assign sts.seg_hit  = (prev_x_r <= qx_r) && (qx_r < rdx_q);
  assign sts.scan_end = idx_r == n_last;
  assign sts.out_busy = out_valid_r && !out_ready;

  assign dy      = {rdy_q[DATA_W-1], rdy_q} - {prev_y_r[DATA_W-1], prev_y_r};
  assign div_try = {rem_r, quo_r[DATA_W-1]};
  assign div_ge  = div_try >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.query_load) begin
      qx_r  <= in_x_value;
      idx_r <= '0;
    end
    if (cmd.chk_last && sts.ge_last) begin
      res_r        <= rdy_q;
      res_status_r <= STATUS_HIGH;
    end
    if (cmd.chk_first) begin
      prev_x_r <= rdx_q;
      prev_y_r <= rdy_q;
      idx_r    <= idx_r + 1'b1;
      if (sts.le_first) begin
        res_r        <= rdy_q;
        res_status_r <= STATUS_LOW;
      end
    end
    if (cmd.scan_step) begin
      if (sts.seg_hit) begin
        y0_r  <= prev_y_r;
        neg_r <= dy[DATA_W];
        mag_r <= dy[DATA_W] ? DATA_W'(-dy) : DATA_W'(dy);
        off_r <= DATA_W'(qx_r - prev_x_r);
        den_r <= DATA_W'(rdx_q - prev_x_r);
      end else if (sts.scan_end) begin
        res_r        <= ONE_VAL;
        res_status_r <= STATUS_NOSEG;
      end else begin
        prev_x_r <= rdx_q;
        prev_y_r <= rdy_q;
        idx_r    <= idx_r + 1'b1;
      end
    end
    if (cmd.mul) begin
      {rem_r, quo_r} <= (2 * DATA_W)'(mag_r) * (2 * DATA_W)'(off_r);
    end
    if (cmd.div_step) begin
      rem_r <= div_ge ? DATA_W'(div_try - {1'b0, den_r}) : div_try[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], div_ge};
    end
    if (cmd.sum) begin
      res_r        <= neg_r ? y0_r - quo_r : y0_r + quo_r;
      res_status_r <= STATUS_INTERP;
    end
    if (cmd.out_load) begin
      out_y_r      <= res_r;
      out_status_r <= res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= CNT_W'(1);
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        entry_count_r <= cfg_wr_data;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_result_y = out_y_r;
  assign out_status   = out_status_r;

endmodule

>>> rtl/core/piecewise_linear_table_interp.sv
// ----------------------------------------------------------------------------
// Piecewise-linear table interpolation
// Breakpoint lookup table with linear interpolation between entries.
// ----------------------------------------------------------------------------
// A load word writes one breakpoint pair. A query word returns one result: it
// is checked first against the last breakpoint, then against the first, and
// only then are the segments scanned, reading one breakpoint per cycle from
// the table memory. A query that falls inside a segment then goes through a
// multiply and a 32-step restoring divider. One word is in work at a time; a
// finished result waits in the output register while the next word is taken.
// Table entries must be loaded before a query reads them.
module piecewise_linear_table_interp import pli_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  pli_in_if.sink           in_ch,
  pli_out_if.source        out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_ch.ready = in_ready;

  pli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pli_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_entry_index (in_ch.entry_index),
    .in_x_value     (in_ch.x_value),
    .in_y_value     (in_ch.y_value),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_result_y   (out_ch.result_y),
    .out_status     (out_ch.status)
  );

endmodule

>>> test/pli_tb_pkg.sv
// ----------------------------------------------------------------------------
// Interpolation scoreboard
// Tracks the breakpoint table and entry count as the block sees them, works
// out the expected result of every accepted query word and compares each
// result word against the oldest expectation.
// ----------------------------------------------------------------------------
package pli_tb_pkg;
  import pli_pkg::*;

  localparam int TB_DEPTH = 16;
  localparam int TB_FRAC  = 16;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_y;
    status_t                  status;
  } interp_result_t;

  class interp_scoreboard;
    logic signed [DATA_W-1:0] bp_x [TB_DEPTH];
    logic signed [DATA_W-1:0] bp_y [TB_DEPTH];
    logic [CNT_W-1:0]         entry_count;
    interp_result_t           awaited [$];
    int                       errors;

    function new();
      entry_count = CNT_W'(1);
      errors = 0;
    endfunction

    function int used_entries();
      if (entry_count < 1) begin
        return 1;
      end
      if (entry_count > TB_DEPTH) begin
        return TB_DEPTH;
      end
      return int'(entry_count);
    endfunction

    function interp_result_t interpolate(logic signed [DATA_W-1:0] x);
      int             n;
      int             i;
      longint         y0;
      longint         dy;
      longint         off;
      longint         den;
      bit [63:0]      mag;
      bit [63:0]      quo;
      interp_result_t r;
      n = used_entries();
      r.result_y = 1 << TB_FRAC;
      r.status = STATUS_NOSEG;
      if (x >= bp_x[n-1]) begin
        r.result_y = bp_y[n-1];
        r.status = STATUS_HIGH;
      end else if (x <= bp_x[0]) begin
        r.result_y = bp_y[0];
        r.status = STATUS_LOW;
      end else begin
        i = 1;
        while (i < n && r.status == STATUS_NOSEG) begin
          if (x >= bp_x[i-1] && x < bp_x[i]) begin
            y0 = longint'(bp_y[i-1]);
            dy = longint'(bp_y[i]) - y0;
            off = longint'(x) - longint'(bp_x[i-1]);
            den = longint'(bp_x[i]) - longint'(bp_x[i-1]);
            mag = (dy < 0) ? 64'(-dy) : 64'(dy);
            quo = (mag * 64'(off)) / 64'(den);
            if (dy < 0) begin
              r.result_y = DATA_W'(y0 - longint'(quo));
            end else begin
              r.result_y = DATA_W'(y0 + longint'(quo));
            end
            r.status = STATUS_INTERP;
          end
          i++;
        end
      end
      return r;
    endfunction

    function void note_word(kind_t kind, logic [IDX_W-1:0] idx,
                            logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] y);
      if (kind == KIND_LOAD) begin
        bp_x[idx] = x;
        bp_y[idx] = y;
      end else begin
        awaited.insert(awaited.size(), interpolate(x));
      end
    endfunction

    function void check_result(logic signed [DATA_W-1:0] ry, logic [1:0] st);
      interp_result_t e;
      if (awaited.size() == 0) begin
        $error("unexpected result word: result_y %0d, status %0d", ry, st);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (ry !== e.result_y) begin
        $error("result_y: expected %0d, actual %0d", $signed(e.result_y), ry);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
    endfunction

    function void close_out();
      if (awaited.size() != 0) begin
        $error("%0d query results never arrived", awaited.size());
        errors += awaited.size();
      end
    endfunction
  endclass

endpackage

>>> test/piecewise_linear_table_interp_tb.sv
// ----------------------------------------------------------------------------
// Piecewise-linear table interpolation testbench
// Loads breakpoint tables of many shapes, sweeps the entry count through its
// range and issues queries below, on, between and above the breakpoints, with
// random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_tb;
  import pli_pkg::*;
  import pli_tb_pkg::*;

  localparam int NUM_PHASES    = 24;
  localparam int PHASE_QUERIES = 24;
  localparam int SETTLE_CYCLES = 64;
  localparam int LIMIT_CYCLES  = 1000000;

  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

  typedef enum int {SHAPE_WIDE, SHAPE_NARROW, SHAPE_UNSORTED} shape_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;
  bit               source_steady = 1'b0;
  bit               sink_steady = 1'b0;
  int unsigned      cycle_count = 0;

  interp_scoreboard sb = new();

  pli_in_if  in_ch ();
  pli_out_if out_ch ();

  piecewise_linear_table_interp #(
    .TABLE_DEPTH(TB_DEPTH),
    .FRAC_BITS  (TB_FRAC)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.result_y, out_ch.status);
    end
  end

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  initial begin : result_sink
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap(sink_steady);
      end
    end
  end

  task automatic send_word(kind_t kind, logic [IDX_W-1:0] idx,
                           logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] y);
    int gap;
    gap = pick_gap(source_steady);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.entry_index <= idx;
    in_ch.x_value <= x;
    in_ch.y_value <= y;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(kind, idx, x, y);
    @(negedge clk);
  endtask

  task automatic send_query(logic signed [DATA_W-1:0] x);
    send_word(KIND_QUERY, IDX_W'($urandom), x, $urandom);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_entry_count(logic [CNT_W-1:0] v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.entry_count = v;
  endtask

  task automatic load_table(int n, shape_t shape);
    logic signed [DATA_W-1:0] xs [TB_DEPTH];
    logic signed [DATA_W-1:0] v;
    int                       shift;
    int                       i;
    int                       j;
    shift = $urandom_range(8, 26);
    for (i = 0; i < n; i++) begin
      xs[i] = (shape == SHAPE_WIDE) ? $signed($urandom) : $signed($urandom) >>> shift;
    end
    if (shape != SHAPE_UNSORTED) begin
      for (i = 1; i < n; i++) begin
        v = xs[i];
        j = i;
        while (j > 0 && xs[j-1] > v) begin
          xs[j] = xs[j-1];
          j--;
        end
        xs[j] = v;
      end
    end
    for (i = 0; i < n; i++) begin
      v = (shape == SHAPE_NARROW) ? $signed($urandom) >>> $urandom_range(0, 28) : $urandom;
      send_word(KIND_LOAD, IDX_W'(i), xs[i], v);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_query_x(int n);
    int     r;
    int     k;
    longint span;
    r = $urandom_range(0, 9);
    k = $urandom_range(0, n - 1);
    if (r <= 1) begin
      return $urandom;
    end
    if (r == 2) begin
      return sb.bp_x[k];
    end
    if (r == 3) begin
      return sb.bp_x[k] + $urandom_range(0, 6) - 3;
    end
    if (r == 4) begin
      return $urandom_range(0, 1) ? Q_MIN : Q_MAX;
    end
    if (n < 2) begin
      return $urandom;
    end
    k = $urandom_range(0, n - 2);
    span = longint'(sb.bp_x[k+1]) - longint'(sb.bp_x[k]);
    if (span <= 0) begin
      return sb.bp_x[k];
    end
    return DATA_W'(longint'(sb.bp_x[k]) + longint'($urandom) % span);
  endfunction

  task automatic run_directed();
    send_word(KIND_LOAD, IDX_W'(0), 32'sh0001_0000, Q_MAX);
    send_query(32'sh0001_0000);
    send_query(-1);
    send_query(Q_MIN);
    send_query(Q_MAX);
    set_entry_count(CNT_W'(0));
    send_query(0);
    set_entry_count(CNT_W'(3));
    send_word(KIND_LOAD, IDX_W'(0), Q_MIN, Q_MIN);
    send_word(KIND_LOAD, IDX_W'(1), 0, Q_MAX);
    send_word(KIND_LOAD, IDX_W'(2), Q_MAX, Q_MIN);
    send_query(Q_MIN);
    send_query(-1);
    send_query(0);
    send_query(32'sh3FFF_FFFF);
    send_query(Q_MAX - 1);
    send_query(Q_MAX);
  endtask

  initial begin : stimulus
    int               p;
    int               q;
    int               r;
    int               n;
    int               k;
    logic [CNT_W-1:0] count;
    shape_t           shape;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD;
    in_ch.entry_index = '0;
    in_ch.x_value = '0;
    in_ch.y_value = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    for (p = 0; p < NUM_PHASES; p++) begin
      r = $urandom_range(0, 19);
      if (p == 0) begin
        count = CNT_W'(TB_DEPTH);
      end else if (r == 0) begin
        count = CNT_W'(0);
      end else if (r == 1) begin
        count = CNT_W'(31);
      end else if (r == 2) begin
        count = CNT_W'(TB_DEPTH + 1);
      end else if (r <= 4) begin
        count = CNT_W'(1);
      end else if (r <= 6) begin
        count = CNT_W'(TB_DEPTH);
      end else begin
        count = CNT_W'($urandom_range(2, TB_DEPTH - 1));
      end
      set_entry_count(count);
      n = sb.used_entries();
      source_steady = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 5);
      shape = (r <= 2) ? SHAPE_WIDE : (r <= 4) ? SHAPE_NARROW : SHAPE_UNSORTED;
      if (p == 0 || $urandom_range(0, 4) != 0) begin
        load_table(n, shape);
      end
      for (q = 0; q < PHASE_QUERIES; q++) begin
        if ($urandom_range(0, 9) == 0) begin
          k = $urandom_range(0, TB_DEPTH - 1);
          if ($urandom_range(0, 1)) begin
            send_word(KIND_LOAD, IDX_W'(k), sb.bp_x[k] + $urandom_range(0, 8) - 4, $urandom);
          end else begin
            send_word(KIND_LOAD, IDX_W'(k), $urandom, $urandom);
          end
        end else begin
          send_query(pick_query_x(n));
        end
      end
    end
    settle();
    sb.close_out();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
